/* sv/wdis_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and the micro-operation program of the wave digital input stage
package wdis_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 32;
    localparam int FRAC      = COEF_W - 4;
    localparam int DRIVE_W   = 20;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SMALL_W   = 34;
    localparam int WIDE_W    = 132;
    localparam int NCOEF     = 17;
    localparam int CIDX_W    = 5;
    localparam int PC_W      = 6;
    localparam int DOT_W     = 67;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int CNT_W     = 8;
    localparam int MUL_STEPS = SMALL_W;
    localparam int DIV_STEPS = WIDE_W;
    localparam int NUM_SHIFT = FRAC + 1;
    localparam int S_SHIFT   = FRAC - (SAMPLE_W - 1);
    localparam int Q_W       = COEF_W + 2;

    localparam logic [CFG_W-1:0] RST_PORT_C1 = 32'd121212;
    localparam logic [CFG_W-1:0] RST_PORT_C4 = 32'd26667;
    localparam logic [CFG_W-1:0] RST_PORT_C6 = 32'd12121212;

    // ohm constants in 1/256 ohm units
    localparam logic [SMALL_W-1:0] C2200_V = 34'd563200;
    localparam logic [SMALL_W-1:0] C10K_V  = 34'd2560000;
    localparam logic [SMALL_W-1:0] C18K_V  = 34'd4608000;
    localparam logic [SMALL_W-1:0] C480K_V = 34'd122880000;
    localparam logic [SMALL_W-1:0] K940_V  = 34'd240640000;
    localparam logic [SMALL_W-1:0] TWO_V   = 34'd2;

    localparam logic [CIDX_W-1:0] K30 = 5'd0;
    localparam logic [CIDX_W-1:0] K33 = 5'd1;
    localparam logic [CIDX_W-1:0] K35 = 5'd2;
    localparam logic [CIDX_W-1:0] K37 = 5'd3;
    localparam logic [CIDX_W-1:0] K40 = 5'd4;
    localparam logic [CIDX_W-1:0] K43 = 5'd5;
    localparam logic [CIDX_W-1:0] K45 = 5'd6;
    localparam logic [CIDX_W-1:0] K47 = 5'd7;
    localparam logic [CIDX_W-1:0] K49 = 5'd8;
    localparam logic [CIDX_W-1:0] K50 = 5'd9;
    localparam logic [CIDX_W-1:0] K55 = 5'd10;
    localparam logic [CIDX_W-1:0] K57 = 5'd11;
    localparam logic [CIDX_W-1:0] K90 = 5'd12;
    localparam logic [CIDX_W-1:0] K93 = 5'd13;
    localparam logic [CIDX_W-1:0] K95 = 5'd14;
    localparam logic [CIDX_W-1:0] K97 = 5'd15;
    localparam logic [CIDX_W-1:0] K99 = 5'd16;

    localparam logic [1:0] D_C4  = 2'd0;
    localparam logic [1:0] D_OUT = 2'd1;
    localparam logic [1:0] D_C6  = 2'd2;
    localparam logic [1:0] D_C1  = 2'd3;

    localparam logic [PC_W-1:0] MAC_START = 6'd41;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PORT_C1, REG_PORT_C4, REG_PORT_C6, REG_REF_VOLTAGE
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_MUL, OP_ADD, OP_ABSD, OP_DIV, OP_NEG, OP_MAC, OP_MARK, OP_END
    } t_op;

    typedef enum logic [2:0] {
        W_CB, W_CX, W_FULL, W_CT, W_T, W_SMALL
    } t_wsel;

    typedef enum logic [3:0] {
        S_Z1, S_Z4, S_Z6, S_DB, S_DC, S_DX, S_TB, S_TX, S_K940, S_TWO, S_C2200, S_C480K
    } t_ssel;

    typedef enum logic [1:0] {
        NEG_NO, NEG_YES, NEG_FLAG
    } t_neg;

    typedef enum logic [2:0] {
        M_S, M_C4, M_C1, M_V, M_C6
    } t_msel;

    typedef struct packed {
        t_op               op;
        t_wsel             dst;
        t_wsel             wa;
        t_wsel             wb;
        t_ssel             sa;
        t_ssel             sb;
        logic [CIDX_W-1:0] cidx;
        logic [CIDX_W-1:0] csrc;
        t_neg              neg;
        t_msel             msel;
        logic              first;
        logic              last;
        logic [1:0]        mdst;
    } t_uop;

    typedef struct packed {
        logic start;
        logic load;
        logic commit;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic need_recompute;
        logic out_free;
    } t_status;

    function automatic t_uop u_op(input t_op op);
        t_uop u;
        u    = '0;
        u.op = op;
        return u;
    endfunction

    function automatic t_uop u_mul(input t_wsel dst, input t_wsel wa, input t_ssel sa,
                                   input t_ssel sb);
        t_uop u;
        u     = u_op(OP_MUL);
        u.dst = dst;
        u.wa  = wa;
        u.sa  = sa;
        u.sb  = sb;
        return u;
    endfunction

    function automatic t_uop u_add(input t_wsel dst, input t_wsel wa, input t_wsel wb);
        t_uop u;
        u     = u_op(OP_ADD);
        u.dst = dst;
        u.wa  = wa;
        u.wb  = wb;
        return u;
    endfunction

    function automatic t_uop u_absd(input t_ssel sa, input t_ssel sb);
        t_uop u;
        u     = u_op(OP_ABSD);
        u.dst = W_T;
        u.sa  = sa;
        u.sb  = sb;
        return u;
    endfunction

    function automatic t_uop u_div(input logic [CIDX_W-1:0] cidx, input t_wsel wb,
                                   input t_ssel sb, input t_neg neg);
        t_uop u;
        u      = u_op(OP_DIV);
        u.cidx = cidx;
        u.wa   = W_T;
        u.wb   = wb;
        u.sb   = sb;
        u.neg  = neg;
        return u;
    endfunction

    function automatic t_uop u_neg(input logic [CIDX_W-1:0] cidx,
                                   input logic [CIDX_W-1:0] csrc, input t_neg neg);
        t_uop u;
        u      = u_op(OP_NEG);
        u.cidx = cidx;
        u.csrc = csrc;
        u.neg  = neg;
        return u;
    endfunction

    function automatic t_uop u_mac(input logic [CIDX_W-1:0] cidx, input t_msel msel,
                                   input logic [1:0] mdst, input logic first,
                                   input logic last);
        t_uop u;
        u       = u_op(OP_MAC);
        u.cidx  = cidx;
        u.msel  = msel;
        u.mdst  = mdst;
        u.first = first;
        u.last  = last;
        return u;
    endfunction

    // coefficient program, then the per-transaction products
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = u_mul(W_CB, W_SMALL, S_DC, S_DB);
            6'd1:  u = u_mul(W_CX, W_SMALL, S_DC, S_DX);
            6'd2:  u = u_mul(W_FULL, W_CB, S_DC, S_DX);
            6'd3:  u = u_mul(W_T, W_SMALL, S_Z6, S_TX);
            6'd4:  u = u_add(W_CT, W_CX, W_T);
            6'd5:  u = u_mul(W_T, W_SMALL, S_K940, S_Z4);
            6'd6:  u = u_div(K30, W_CB, S_DC, NEG_NO);
            6'd7:  u = u_neg(K35, K30, NEG_YES);
            6'd8:  u = u_absd(S_C2200, S_Z4);
            6'd9:  u = u_div(K33, W_SMALL, S_DC, NEG_FLAG);
            6'd10: u = u_mul(W_T, W_SMALL, S_Z4, S_TB);
            6'd11: u = u_mul(W_T, W_T, S_Z4, S_TWO);
            6'd12: u = u_div(K37, W_CB, S_DC, NEG_NO);
            6'd13: u = u_mul(W_T, W_CT, S_Z4, S_K940);
            6'd14: u = u_div(K40, W_FULL, S_DC, NEG_NO);
            6'd15: u = u_neg(K45, K40, NEG_YES);
            6'd16: u = u_mul(W_T, W_SMALL, S_Z6, S_TX);
            6'd17: u = u_mul(W_T, W_T, S_Z6, S_TWO);
            6'd18: u = u_div(K43, W_CX, S_DC, NEG_YES);
            6'd19: u = u_neg(K93, K43, NEG_NO);
            6'd20: u = u_mul(W_T, W_CT, S_Z6, S_TB);
            6'd21: u = u_mul(W_T, W_T, S_Z6, S_TWO);
            6'd22: u = u_div(K47, W_FULL, S_DC, NEG_NO);
            6'd23: u = u_mul(W_T, W_SMALL, S_TX, S_TWO);
            6'd24: u = u_div(K49, W_SMALL, S_DX, NEG_NO);
            6'd25: u = u_mul(W_T, W_SMALL, S_Z1, S_TWO);
            6'd26: u = u_div(K50, W_SMALL, S_DB, NEG_NO);
            6'd27: u = u_neg(K57, K50, NEG_YES);
            6'd28: u = u_absd(S_C480K, S_Z1);
            6'd29: u = u_div(K55, W_SMALL, S_DB, NEG_FLAG);
            6'd30: u = u_mul(W_T, W_SMALL, S_Z6, S_TX);
            6'd31: u = u_mul(W_T, W_T, S_Z6, S_K940);
            6'd32: u = u_div(K90, W_FULL, S_DC, NEG_NO);
            6'd33: u = u_neg(K95, K90, NEG_YES);
            6'd34: u = u_mul(W_T, W_SMALL, S_Z6, S_TB);
            6'd35: u = u_mul(W_T, W_T, S_Z6, S_TX);
            6'd36: u = u_mul(W_T, W_T, S_Z6, S_TWO);
            6'd37: u = u_div(K97, W_FULL, S_DC, NEG_NO);
            6'd38: u = u_absd(S_TX, S_Z6);
            6'd39: u = u_div(K99, W_SMALL, S_DX, NEG_FLAG);
            6'd40: u = u_op(OP_MARK);
            6'd41: u = u_mac(K30, M_S, D_C4, 1'b1, 1'b0);
            6'd42: u = u_mac(K33, M_C4, D_C4, 1'b0, 1'b0);
            6'd43: u = u_mac(K35, M_C1, D_C4, 1'b0, 1'b0);
            6'd44: u = u_mac(K37, M_V, D_C4, 1'b0, 1'b1);
            6'd45: u = u_mac(K40, M_S, D_OUT, 1'b1, 1'b0);
            6'd46: u = u_mac(K43, M_C4, D_OUT, 1'b0, 1'b0);
            6'd47: u = u_mac(K45, M_C1, D_OUT, 1'b0, 1'b0);
            6'd48: u = u_mac(K47, M_V, D_OUT, 1'b0, 1'b0);
            6'd49: u = u_mac(K49, M_C6, D_OUT, 1'b0, 1'b1);
            6'd50: u = u_mac(K90, M_S, D_C6, 1'b1, 1'b0);
            6'd51: u = u_mac(K93, M_C4, D_C6, 1'b0, 1'b0);
            6'd52: u = u_mac(K95, M_C1, D_C6, 1'b0, 1'b0);
            6'd53: u = u_mac(K97, M_V, D_C6, 1'b0, 1'b0);
            6'd54: u = u_mac(K99, M_C6, D_C6, 1'b0, 1'b1);
            6'd55: u = u_mac(K50, M_S, D_C1, 1'b1, 1'b0);
            6'd56: u = u_mac(K55, M_C1, D_C1, 1'b0, 1'b0);
            6'd57: u = u_mac(K57, M_V, D_C1, 1'b0, 1'b1);
            default: u = u_op(OP_END);
        endcase
        return u;
    endfunction

endpackage

/* sv/wave_digital_input_stage.sv */
`timescale 1ns / 1ps
// top level of the wave digital input stage: controller and datapath
//
// channel | handshake                 | payload
// input   | i_in_valid / o_in_ready   | i_in_sample, i_drive_ohms
// output  | o_out_valid / i_out_ready | o_out_sample
// config  | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// when drive and port resistances are unchanged, a transaction runs 17 products through
// one 32x32 multiply-accumulate. when coefficients are recomputed, 12 divisions of 132
// steps in the restoring divider and 19 products of 34 steps in the shift-add multiplier
// come first.
// synchronous active-low reset; no clearing pass, first transaction recomputes.
// a finished result waits in the output register; the next transaction is taken
// meanwhile and holds in its last step until that register is free.
module wave_digital_input_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wdis_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wdis_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [wdis_pkg::SAMPLE_W-1:0] i_in_sample,
    input  logic [wdis_pkg::DRIVE_W-1:0]        i_drive_ohms,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [wdis_pkg::SAMPLE_W-1:0] o_out_sample
);
    import wdis_pkg::*;

    t_cmd    cmd;
    t_status status;

    wdis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wdis_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_sample  (i_in_sample),
        .i_drive_ohms (i_drive_ohms),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_sample (o_out_sample),
        .i_cmd        (cmd),
        .o_status     (status)
    );

endmodule

/* sv/wdis_ctrl.sv */
`timescale 1ns / 1ps
// controller: sequences the micro-operation program over the datapath
module wdis_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wdis_pkg::t_status i_status,
    output wdis_pkg::t_cmd    o_cmd
);
    import wdis_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_ISSUE, ST_WAIT, ST_OUT} t_state;

    t_state          r_state;
    logic [PC_W-1:0] r_pc;
    t_uop            uop;

    assign uop = uop_rom(r_pc);

    always_comb begin
        o_cmd.uop    = uop;
        o_cmd.start  = (r_state == ST_ISSUE) && (uop.op != OP_END);
        o_cmd.load   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.commit = (r_state == ST_OUT) && i_status.out_free;
        o_in_ready   = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_pc    <= i_status.need_recompute ? '0 : MAC_START;
                    r_state <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    r_state <= (uop.op == OP_END) ? ST_OUT : ST_WAIT;
                end
                ST_WAIT: begin
                    if (i_status.done) begin
                        r_pc    <= r_pc + 1'b1;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_OUT: begin
                    if (i_status.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

/* sv/wdis_datapath.sv */
`timescale 1ns / 1ps
// datapath: configuration, shift-add multiplier, restoring divider, coefficient store, mac
module wdis_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wdis_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wdis_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic signed [wdis_pkg::SAMPLE_W-1:0] i_in_sample,
    input  logic [wdis_pkg::DRIVE_W-1:0]        i_drive_ohms,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [wdis_pkg::SAMPLE_W-1:0] o_out_sample,
    input  wdis_pkg::t_cmd                      i_cmd,
    output wdis_pkg::t_status                   o_status
);
    import wdis_pkg::*;

    localparam logic [Q_W-1:0] MAXQ = Q_W'((64'd1 << (COEF_W - 1)) - 64'd1);

    logic [CFG_W-1:0]         r_port_c1, r_port_c4, r_port_c6;
    logic signed [COEF_W-1:0] r_ref_voltage;
    logic                     r_coefs_valid;
    logic [DRIVE_W-1:0]       r_last_drive, r_drive;
    logic signed [COEF_W-1:0] r_s;
    logic signed [COEF_W-1:0] r_wave_c1, r_wave_c4, r_wave_c6;
    logic signed [COEF_W-1:0] r_coef [NCOEF];
    logic [WIDE_W-1:0]        r_cb, r_cx, r_full, r_ct, r_t;
    logic                     r_diff_neg;
    logic                     r_busy, r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic [WIDE_W-1:0]        r_acc, r_mcand, r_rem, r_num, r_den;
    logic [SMALL_W-1:0]       r_mplier;
    logic [Q_W-1:0]           r_q;
    logic                     r_over;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DOT_W-1:0]  r_macc;
    logic signed [COEF_W-1:0] r_dot [4];
    logic                     r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;

    t_uop               uop;
    logic [SMALL_W-1:0] v_z1, v_z4, v_z6, v_x, v_db, v_dc, v_dx, v_tb, v_tx;
    logic [SMALL_W-1:0] sa_val, sb_val;
    logic [WIDE_W-1:0]  wa_val, wb_val;
    logic [WIDE_W-1:0]  acc_n;
    logic [WIDE_W:0]    rem_sh;
    logic               ge;
    logic [WIDE_W-1:0]  rem_n;
    logic [Q_W-1:0]     q_n;
    logic               over_n;
    logic [Q_W-1:0]     qr;
    logic [COEF_W-1:0]  mag;
    logic               div_neg;
    logic [COEF_W-1:0]  div_val;
    logic               wb_en;
    logic [WIDE_W-1:0]  wr_val;
    logic               cw_en;
    logic [COEF_W-1:0]  cw_val;
    logic               done_n;
    logic [CIDX_W-1:0]  rd_addr;
    logic signed [COEF_W-1:0] c_rd, m_op;
    logic signed [PROD_W-1:0] prod;
    logic signed [DOT_W-1:0]  acc_sum, acc_rnd, acc_sh;
    logic signed [COEF_W-1:0] dot_val;
    logic               finish;
    logic signed [COEF_W:0]   o_ext, o_sh;
    logic signed [SAMPLE_W-1:0] o_val;

    function automatic logic [SMALL_W-1:0] small_pick(input t_ssel sel);
        logic [SMALL_W-1:0] v;
        case (sel)
            S_Z1:    v = v_z1;
            S_Z4:    v = v_z4;
            S_Z6:    v = v_z6;
            S_DB:    v = v_db;
            S_DC:    v = v_dc;
            S_DX:    v = v_dx;
            S_TB:    v = v_tb;
            S_TX:    v = v_tx;
            S_K940:  v = K940_V;
            S_TWO:   v = TWO_V;
            S_C2200: v = C2200_V;
            S_C480K: v = C480K_V;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [WIDE_W-1:0] wide_pick(input t_wsel sel,
                                                   input logic [SMALL_W-1:0] sv);
        logic [WIDE_W-1:0] v;
        case (sel)
            W_CB:    v = r_cb;
            W_CX:    v = r_cx;
            W_FULL:  v = r_full;
            W_CT:    v = r_ct;
            W_T:     v = r_t;
            W_SMALL: v = WIDE_W'(sv);
            default: v = '0;
        endcase
        return v;
    endfunction

    assign uop = i_cmd.uop;

    // port resistances and sums in 1/256 ohm
    always_comb begin
        v_z1 = SMALL_W'(r_port_c1);
        v_z4 = SMALL_W'(r_port_c4);
        v_z6 = SMALL_W'(r_port_c6);
        v_x  = SMALL_W'({r_drive, 8'd0});
        v_db = v_z1 + C480K_V;
        v_dc = v_z4 + C2200_V;
        v_tb = v_z1 + C10K_V;
        v_tx = v_x + C18K_V;
        v_dx = v_tx + v_z6;
    end

    always_comb begin
        sa_val = small_pick(uop.sa);
        sb_val = small_pick(uop.sb);
        wa_val = wide_pick(uop.wa, sa_val);
        wb_val = wide_pick(uop.wb, sb_val);
    end

    // shift-add multiplier step
    assign acc_n = r_mplier[0] ? (r_acc + r_mcand) : r_acc;

    // restoring divider step and quotient rounding
    always_comb begin
        rem_sh  = {r_rem, r_num[WIDE_W-1]};
        ge      = (rem_sh >= {1'b0, r_den});
        rem_n   = ge ? WIDE_W'(rem_sh - {1'b0, r_den}) : rem_sh[WIDE_W-1:0];
        q_n     = {r_q[Q_W-2:0], ge};
        over_n  = r_over | q_n[Q_W-1];
        qr      = Q_W'(({1'b0, q_n} + {{Q_W{1'b0}}, 1'b1}) >> 1);
        mag     = (over_n || (qr > MAXQ)) ? MAXQ[COEF_W-1:0] : qr[COEF_W-1:0];
        div_neg = (uop.neg == NEG_YES) || ((uop.neg == NEG_FLAG) && r_diff_neg);
        div_val = div_neg ? (~mag + 1'b1) : mag;
    end

    assign finish = r_busy && (r_cnt == CNT_W'(1));

    // coefficient read, one port, and the multiply-accumulate with rounding and saturation
    always_comb begin
        rd_addr = (uop.op == OP_NEG) ? uop.csrc : uop.cidx;
        c_rd    = r_coef[rd_addr];
        case (uop.msel)
            M_S:     m_op = r_s;
            M_C4:    m_op = r_wave_c4;
            M_C1:    m_op = r_wave_c1;
            M_V:     m_op = r_ref_voltage;
            M_C6:    m_op = r_wave_c6;
            default: m_op = '0;
        endcase
        prod    = PROD_W'(c_rd) * PROD_W'(m_op);
        acc_sum = (uop.first ? DOT_W'(0) : r_macc) + DOT_W'(r_prod);
        acc_rnd = acc_sum + (DOT_W'(1) <<< (FRAC - 1));
        acc_sh  = acc_rnd >>> FRAC;
        if (acc_sh > DOT_W'(64'sh7FFF_FFFF)) begin
            dot_val = {1'b0, {(COEF_W-1){1'b1}}};
        end else if (acc_sh < -DOT_W'(64'sh8000_0000)) begin
            dot_val = {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
            dot_val = acc_sh[COEF_W-1:0];
        end
    end

    // write-back selection
    always_comb begin
        wb_en  = 1'b0;
        wr_val = acc_n;
        cw_en  = 1'b0;
        cw_val = div_val;
        done_n = finish;
        if (i_cmd.start) begin
            case (uop.op)
                OP_ADD: begin
                    wb_en  = 1'b1;
                    wr_val = wa_val + wb_val;
                end
                OP_ABSD: begin
                    wb_en  = 1'b1;
                    wr_val = (sa_val >= sb_val) ? WIDE_W'(sa_val - sb_val)
                                                : WIDE_W'(sb_val - sa_val);
                end
                OP_NEG: begin
                    cw_en  = 1'b1;
                    cw_val = (uop.neg == NEG_YES) ? (~c_rd + 1'b1) : c_rd;
                end
                default: ;
            endcase
            case (uop.op) inside
                OP_MUL, OP_DIV, OP_MAC: done_n = 1'b0;
                default:                done_n = 1'b1;
            endcase
        end
        if (finish && (uop.op == OP_MUL)) begin
            wb_en = 1'b1;
        end
        if (finish && (uop.op == OP_DIV)) begin
            cw_en = 1'b1;
        end
    end

    // output rounding: half of the output wave rescaled to the sample format
    always_comb begin
        o_ext = {r_dot[D_OUT][COEF_W-1], r_dot[D_OUT]} + (COEF_W+1)'(1 <<< (FRAC - SAMPLE_W + 1));
        o_sh  = o_ext >>> (FRAC - SAMPLE_W + 2);
        if (o_sh > (COEF_W+1)'((1 <<< (SAMPLE_W - 1)) - 1)) begin
            o_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (o_sh < -(COEF_W+1)'(1 <<< (SAMPLE_W - 1))) begin
            o_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            o_val = o_sh[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_c1     <= RST_PORT_C1;
            r_port_c4     <= RST_PORT_C4;
            r_port_c6     <= RST_PORT_C6;
            r_ref_voltage <= '0;
            r_coefs_valid <= 1'b0;
            r_last_drive  <= '0;
            r_wave_c1     <= '0;
            r_wave_c4     <= '0;
            r_wave_c6     <= '0;
            r_busy        <= 1'b0;
            r_done        <= 1'b0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_done <= done_n;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_PORT_C1: begin
                        r_port_c1     <= i_cfg_data;
                        r_coefs_valid <= 1'b0;
                    end
                    REG_PORT_C4: begin
                        r_port_c4     <= i_cfg_data;
                        r_coefs_valid <= 1'b0;
                    end
                    REG_PORT_C6: begin
                        r_port_c6     <= i_cfg_data;
                        r_coefs_valid <= 1'b0;
                    end
                    REG_REF_VOLTAGE: r_ref_voltage <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                case (uop.op)
                    OP_MUL: begin
                        r_busy <= 1'b1;
                        r_cnt  <= CNT_W'(MUL_STEPS);
                    end
                    OP_DIV: begin
                        r_busy <= 1'b1;
                        r_cnt  <= CNT_W'(DIV_STEPS);
                    end
                    OP_MAC: begin
                        r_busy <= 1'b1;
                        r_cnt  <= CNT_W'(1);
                    end
                    OP_MARK: begin
                        r_coefs_valid <= 1'b1;
                        r_last_drive  <= r_drive;
                    end
                    default: ;
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (finish) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                r_wave_c4   <= r_dot[D_C4];
                r_wave_c6   <= r_dot[D_C6];
                r_wave_c1   <= r_dot[D_C1];
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_drive <= i_drive_ohms;
            r_s     <= {{(COEF_W-SAMPLE_W-S_SHIFT){i_in_sample[SAMPLE_W-1]}},
                        i_in_sample, {S_SHIFT{1'b0}}};
        end
        if (i_cmd.start) begin
            r_acc    <= '0;
            r_mcand  <= wa_val;
            r_mplier <= sb_val;
            r_rem    <= '0;
            r_num    <= wa_val << NUM_SHIFT;
            r_den    <= wb_val;
            r_q      <= '0;
            r_over   <= 1'b0;
            r_prod   <= prod;
            if (uop.op == OP_ABSD) begin
                r_diff_neg <= (sa_val < sb_val);
            end
        end else if (r_busy) begin
            r_acc    <= acc_n;
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
            r_rem    <= rem_n;
            r_num    <= r_num << 1;
            r_q      <= q_n;
            r_over   <= over_n;
            if (uop.op == OP_MAC) begin
                r_macc <= acc_sum;
                if (uop.last) begin
                    r_dot[uop.mdst] <= dot_val;
                end
            end
        end
        if (wb_en) begin
            case (uop.dst)
                W_CB:    r_cb   <= wr_val;
                W_CX:    r_cx   <= wr_val;
                W_FULL:  r_full <= wr_val;
                W_CT:    r_ct   <= wr_val;
                default: r_t    <= wr_val;
            endcase
        end
        if (cw_en) begin
            r_coef[uop.cidx] <= cw_val;
        end
        if (i_cmd.commit) begin
            r_out_sample <= o_val;
        end
    end

    always_comb begin
        o_status.done           = r_done;
        o_status.need_recompute = !r_coefs_valid || (r_drive != r_last_drive);
        o_status.out_free       = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

endmodule

/* sv/wdis_checker.sv */
`timescale 1ns / 1ps
// port-level checker for the wave digital input stage, bound to the top level
module wdis_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [wdis_pkg::SAMPLE_W-1:0] o_out_sample
);

    a_reset_empty : assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_sample))
        else $error("stalled output transaction changed");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after input transaction");

    a_result_frees_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result shown while still busy");

endmodule

bind wave_digital_input_stage wdis_checker u_wdis_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_sample (o_out_sample)
);

/* test/wave_digital_input_stage_test.sv */
`timescale 1ns / 1ps
// self-checking testbench of the wave digital input stage with a bit-exact scoreboard
module wave_digital_input_stage_test;
    import wdis_pkg::*;

    localparam int WATCH_LIMIT = 40000;
    localparam int DRAIN_WAIT  = 200;
    localparam int HOLD_LEN    = 600;

    typedef logic [199:0] wide_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [SAMPLE_W-1:0] smp_t;

    class wave_stage_board;
        logic [CFG_W-1:0] port_c1, port_c4, port_c6, vref;
        coef_t            st_c1, st_c4, st_c6;
        coef_t            coef [NCOEF];
        logic [DRIVE_W-1:0] prev_drive;
        bit               coefs_ok;
        smp_t             out_q [$];
        int               errors, n_in, n_out, n_recalc;

        function new();
            port_c1    = RST_PORT_C1;
            port_c4    = RST_PORT_C4;
            port_c6    = RST_PORT_C6;
            vref       = '0;
            st_c1      = '0;
            st_c4      = '0;
            st_c6      = '0;
            prev_drive = '0;
            coefs_ok   = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [CFG_W-1:0] d);
            case (idx)
                REG_PORT_C1: begin port_c1 = d; coefs_ok = 0; end
                REG_PORT_C4: begin port_c4 = d; coefs_ok = 0; end
                REG_PORT_C6: begin port_c6 = d; coefs_ok = 0; end
                REG_REF_VOLTAGE: vref = d;
            endcase
        endfunction

        // rounded quotient in Q4.28, magnitude saturated
        function coef_t quot(wide_t num, wide_t den, bit neg);
            wide_t       q;
            logic [33:0] r;
            if (den == 0) begin
                r = 34'h7FFFFFFF;
            end else begin
                q = (num << (FRAC + 1)) / den;
                if (q >= (wide_t'(1) << (COEF_W + 1))) begin
                    r = 34'h7FFFFFFF;
                end else begin
                    r = (q[33:0] + 34'd1) >> 1;
                    if (r > 34'h7FFFFFFF) r = 34'h7FFFFFFF;
                end
            end
            return neg ? -coef_t'(r[30:0]) : coef_t'(r[30:0]);
        endfunction

        function coef_t quot_diff(wide_t p, wide_t m, wide_t den);
            if (p >= m) return quot(p - m, den, 0);
            return quot(m - p, den, 1);
        endfunction

        function void recalc(logic [DRIVE_W-1:0] drv);
            wide_t z1, z4, z6, x, db, dc, dx, tb, tx, k, cx, cb, full, ct;
            z1   = port_c1;
            z4   = port_c4;
            z6   = port_c6;
            x    = wide_t'(drv) << 8;
            k    = K940_V;
            db   = z1 + C480K_V;
            dc   = z4 + C2200_V;
            dx   = x + z6 + C18K_V;
            tb   = z1 + C10K_V;
            tx   = x + C18K_V;
            cx   = dc * dx;
            cb   = dc * db;
            full = cb * dx;
            ct   = cx + z6 * tx;
            coef[K30] = quot(k * z4, cb, 0);
            coef[K35] = -coef[K30];
            coef[K33] = quot_diff(C2200_V, z4, dc);
            coef[K37] = quot(2 * z4 * tb, cb, 0);
            coef[K40] = quot(k * ct, full, 0);
            coef[K45] = -coef[K40];
            coef[K43] = quot(2 * z6 * tx, cx, 1);
            coef[K93] = coef[K43];
            coef[K47] = quot(2 * tb * ct, full, 0);
            coef[K49] = quot(2 * tx, dx, 0);
            coef[K50] = quot(2 * z1, db, 0);
            coef[K57] = -coef[K50];
            coef[K55] = quot_diff(C480K_V, z1, db);
            coef[K90] = quot(k * z6 * tx, full, 0);
            coef[K95] = -coef[K90];
            coef[K97] = quot(2 * z6 * tb * tx, full, 0);
            coef[K99] = quot_diff(tx, z6, dx);
            n_recalc++;
        endfunction

        // exact sum of products, rounded half up to Q4.28, saturated
        function coef_t mac(coef_t c0, coef_t v0, coef_t c1, coef_t v1, coef_t c2, coef_t v2,
                            coef_t c3, coef_t v3, coef_t c4, coef_t v4);
            logic signed [79:0] acc;
            acc = 80'(c0) * 80'(v0) + 80'(c1) * 80'(v1) + 80'(c2) * 80'(v2)
                + 80'(c3) * 80'(v3) + 80'(c4) * 80'(v4);
            acc = (acc + (80'sd1 <<< (FRAC - 1))) >>> FRAC;
            if (acc > 80'sh7FFFFFFF) return coef_t'(32'h7FFFFFFF);
            if (acc < -80'sh80000000) return coef_t'(32'h80000000);
            return coef_t'(acc);
        endfunction

        function void note_input(smp_t smp, logic [DRIVE_W-1:0] drv);
            coef_t s, v, n4, wout, n1, n6;
            logic signed [39:0] o;
            if (!coefs_ok || drv != prev_drive) begin
                recalc(drv);
                prev_drive = drv;
                coefs_ok   = 1;
            end
            s    = coef_t'(smp) <<< S_SHIFT;
            v    = coef_t'(vref);
            n4   = mac(coef[K30], s, coef[K33], st_c4, coef[K35], st_c1, coef[K37], v, 0, 0);
            wout = mac(coef[K40], s, coef[K43], st_c4, coef[K45], st_c1, coef[K47], v,
                       coef[K49], st_c6);
            n6   = mac(coef[K90], s, coef[K93], st_c4, coef[K95], st_c1, coef[K97], v,
                       coef[K99], st_c6);
            n1   = mac(coef[K50], s, coef[K55], st_c1, coef[K57], v, 0, 0, 0, 0);
            st_c1 = n1;
            st_c4 = n4;
            st_c6 = n6;
            o = (40'(wout) + 40'sd32) >>> 6;
            if (o > 40'sh7FFFFF) o = 40'sh7FFFFF;
            if (o < -40'sh800000) o = -40'sh800000;
            out_q.push_back(smp_t'(o));
            n_in++;
        endfunction

        function void check_result(smp_t got);
            smp_t want;
            n_out++;
            if (out_q.size() == 0) begin
                $display("%0t: unexpected output sample %0d", $time, got);
                errors++;
                return;
            end
            want = out_q.pop_front();
            if (got !== want) begin
                $display("%0t: out_sample mismatch, expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    smp_t                i_in_sample;
    logic [DRIVE_W-1:0]  i_drive_ohms;
    logic                o_out_valid;
    logic                i_out_ready;
    smp_t                o_out_sample;

    wave_stage_board board;
    bit              hold_rx;
    bit              no_idle;
    int              idle_cycles;
    logic [DRIVE_W-1:0] cur_drive;

    wave_digital_input_stage dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_sample (i_in_sample),
        .i_drive_ohms(i_drive_ohms),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_sample(o_out_sample)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 250);
    endfunction

    // transaction monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) board.note_input(i_in_sample, i_drive_ohms);
            if (o_out_valid && i_out_ready) board.check_result(o_out_sample);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    // receiver
    initial begin
        int stall;
        i_out_ready = 1'b0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                stall--;
            end else if (hold_rx) begin
                i_out_ready = 1'b0;
                stall = HOLD_LEN;
                hold_rx = 0;
            end else begin
                i_out_ready = 1'b1;
                if ($urandom_range(0, 99) < 20) stall = pick_gap();
            end
        end
    end

    initial begin
        while (idle_cycles < WATCH_LIMIT) @(posedge i_clk);
        $display("timeout after %0d quiet cycles", idle_cycles);
        $display("[wave_digital_input_stage] ERROR");
        $finish;
    end

    task automatic send(smp_t smp, logic [DRIVE_W-1:0] drv);
        int gap;
        i_in_valid   = 1'b1;
        i_in_sample  = smp;
        i_drive_ohms = drv;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (board.out_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] d);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = d;
        board.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_ports(logic [CFG_W-1:0] c1, logic [CFG_W-1:0] c4,
                             logic [CFG_W-1:0] c6, logic [CFG_W-1:0] vr);
        write_reg(REG_PORT_C1, c1);
        write_reg(REG_PORT_C4, c4);
        write_reg(REG_PORT_C6, c6);
        write_reg(REG_REF_VOLTAGE, vr);
    endtask

    task automatic random_items(int n);
        smp_t smp;
        int   r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) cur_drive = $urandom_range(0, 1) ? '1 : '0;
            else if (r < 16) cur_drive = DRIVE_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 6) smp = {1'b0, {(SAMPLE_W-1){1'b1}}};
            else if (r < 12) smp = {1'b1, {(SAMPLE_W-1){1'b0}}};
            else if (r < 40) smp = smp_t'($signed($urandom_range(0, 8191)) - 4096);
            else smp = smp_t'($urandom);
            send(smp, cur_drive);
        end
    endtask

    initial begin
        board        = new();
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_PORT_C1;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_in_sample  = '0;
        i_drive_ohms = '0;
        hold_rx      = 0;
        no_idle      = 0;
        idle_cycles  = 0;
        cur_drive    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes, repeated drive, drive change, saturating states
        send(24'sh7FFFFF, '0);
        send(-24'sh800000, '0);
        send('0, '1);
        send(-24'sd1, '1);
        for (int i = 0; i < 6; i++) send(24'sh7FFFFF, '1);
        for (int i = 0; i < 4; i++) send(-24'sh800000, 20'd4700);
        send(24'sd1, 20'd12345);
        drain();
        set_ports(32'd1, 32'd1, 32'd1, 32'h7FFFFFFF);
        send(24'sh7FFFFF, '0);
        send(-24'sh800000, '1);
        for (int i = 0; i < 4; i++) send(24'sh7FFFFF, '1);
        drain();
        set_ports('1, '1, '1, 32'h80000000);
        send(-24'sh800000, '0);
        send(24'sh7FFFFF, '1);
        send('0, '1);
        drain();
        set_ports('0, '0, '0, '0);
        send(24'sh7FFFFF, '0);
        send(24'sh400000, '1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_ports(RST_PORT_C1, RST_PORT_C4, RST_PORT_C6, '0);
                1: set_ports(32'd1, '1, 32'd1, 32'h7FFFFFFF);
                2: set_ports('1, 32'd1, '1, 32'h80000000);
                7: set_ports(RST_PORT_C1, RST_PORT_C4, RST_PORT_C6, $urandom);
                default: set_ports($urandom_range(1, 1 << 26), $urandom_range(1, 1 << 22),
                                   $urandom_range(1, 1 << 28), $urandom);
            endcase
            no_idle = (ph == 4);
            cur_drive = DRIVE_W'($urandom);
            if (ph == 2) begin
                random_items(10);
                hold_rx = 1;
                random_items(60);
            end else if (ph == 3) begin
                random_items(30);
                drain();
                random_items(40);
            end else begin
                random_items(68);
            end
            drain();
        end

        repeat (DRAIN_WAIT) @(negedge i_clk);
        $display("%0d samples in, %0d out, %0d coefficient sets, port and reference extremes",
                 board.n_in, board.n_out, board.n_recalc);
        if (board.errors == 0 && board.out_q.size() == 0) begin
            $display("[wave_digital_input_stage] OK");
        end else begin
            $display("%0d errors, %0d outputs missing", board.errors, board.out_q.size());
            $display("[wave_digital_input_stage] ERROR");
        end
        $finish;
    end

endmodule
